// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/gdbd_pkg.sv =====
// ----------------------------------------------------------------------------
// gdbd_pkg
// Widths, constants, stage types and month table for the day distance block.
// ----------------------------------------------------------------------------
package gdbd_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned COUNT_W = 23;
	localparam int unsigned DIST_W  = 22;
	localparam int unsigned DBM_W   = 9;
	localparam int unsigned Q4_W    = YEAR_W - 2;
	localparam int unsigned Q100_W  = 8;

	localparam int unsigned MAX_YEAR_DEF = 9999;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT for x below 4096
	localparam int unsigned RECIP_W     = 13;
	localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;
	localparam int unsigned RECIP_SHIFT = 17;
	localparam int unsigned PROD_W      = Q4_W + RECIP_W;

	localparam logic [MONTH_W-1:0] MONTH_MARCH = 4'd3;

	typedef struct packed {
		logic [YEAR_W-1:0] n;
		logic [Q4_W-1:0]   q4;
		logic [Q4_W-1:0]   yq4;
		logic [1:0]        ylo;
		logic [DAY_W-1:0]  d;
		logic [DBM_W-1:0]  dbm;
		logic              late;
	} st1_t;

	typedef struct packed {
		logic [COUNT_W-1:0] base;
		logic [Q100_W-1:0]  q100;
		logic [Q100_W-1:0]  yq100;
		logic [Q4_W-1:0]    yq4;
		logic [1:0]         ylo;
		logic               late;
	} st2_t;

	function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [DBM_W-1:0] r;
		unique case (m)
			4'd0, 4'd1: r = 9'd0;
			4'd2:       r = 9'd31;
			4'd3:       r = 9'd59;
			4'd4:       r = 9'd90;
			4'd5:       r = 9'd120;
			4'd6:       r = 9'd151;
			4'd7:       r = 9'd181;
			4'd8:       r = 9'd212;
			4'd9:       r = 9'd243;
			4'd10:      r = 9'd273;
			4'd11:      r = 9'd304;
			4'd12:      r = 9'd334;
			default:    r = 9'd365;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/gregorian_days_between_dates.sv =====
// ----------------------------------------------------------------------------
// gregorian_days_between_dates
// Absolute day distance between two proleptic Gregorian dates, pipelined.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        handshake
//  s_axis   in   two dates (day, month, year each), 48b tdata   tvalid/tready
//  m_axis   out  day_distance, 24b tdata                        tvalid/tready
//
//  One date pair per cycle sustained while m_tready stays high; the accepting
//  edge loads the first of four register stages (clamp and month table,
//  reciprocal multiplies for /100, day count, difference and clamp), and
//  m_tvalid rises when the fourth stage is loaded.
//  arst_n clears the stage valid bits only; the data path registers are not reset.
//  Each stage holds when the stage after it is full and stalled, so bubbles
//  are filled and s_tready drops only when all four stages are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gregorian_days_between_dates
	import gdbd_pkg::*;
#(
	parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// first_day, first_month, first_year, second_day, second_month,
	// second_year, 2'b0 pad
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// day_distance, 2'b0 pad
	output logic [23:0] m_tdata
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	st1_t               st_s1 [2];
	st2_t               st_s2 [2];
	logic [COUNT_W-1:0] cnt_s3 [2];
	logic [DIST_W-1:0]  dist_s4;

	st1_t               nx1 [2];
	st2_t               nx2 [2];
	logic [COUNT_W-1:0] nx3 [2];
	logic [DIST_W-1:0]  nx4;

	logic [DAY_W-1:0]   in_d [2];
	logic [MONTH_W-1:0] in_m [2];
	logic [YEAR_W-1:0]  in_y [2];

	assign in_d[0] = s_tdata[4:0];
	assign in_m[0] = s_tdata[8:5];
	assign in_y[0] = s_tdata[22:9];
	assign in_d[1] = s_tdata[27:23];
	assign in_m[1] = s_tdata[31:28];
	assign in_y[1] = s_tdata[45:32];

	assign en4      = !v_s4 || m_tready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;

	always_comb begin
		logic [YEAR_W-1:0] y;
		for (int i = 0; i < 2; i++) begin
			y = in_y[i];
			if (32'(in_y[i]) > MAX_YEAR) begin
				y = YEAR_W'(MAX_YEAR);
			end
			nx1[i].n    = (y == '0) ? '0 : y - YEAR_W'(1);
			nx1[i].q4   = nx1[i].n[YEAR_W-1:2];
			nx1[i].yq4  = y[YEAR_W-1:2];
			nx1[i].ylo  = y[1:0];
			nx1[i].d    = in_d[i];
			nx1[i].dbm  = days_before_month(in_m[i]);
			nx1[i].late = (in_m[i] >= MONTH_MARCH);
		end
	end

	always_comb begin
		logic [PROD_W-1:0] p_n;
		logic [PROD_W-1:0] p_y;
		for (int i = 0; i < 2; i++) begin
			p_n = PROD_W'(st_s1[i].q4) * PROD_W'(RECIP_25);
			p_y = PROD_W'(st_s1[i].yq4) * PROD_W'(RECIP_25);
			nx2[i].q100  = p_n[PROD_W-1:RECIP_SHIFT];
			nx2[i].yq100 = p_y[PROD_W-1:RECIP_SHIFT];
			nx2[i].base  = COUNT_W'(st_s1[i].n) * COUNT_W'(365)
				+ COUNT_W'(st_s1[i].q4) + COUNT_W'(st_s1[i].d)
				+ COUNT_W'(st_s1[i].dbm);
			nx2[i].yq4   = st_s1[i].yq4;
			nx2[i].ylo   = st_s1[i].ylo;
			nx2[i].late  = st_s1[i].late;
		end
	end

	always_comb begin
		logic c100;
		logic leap;
		for (int i = 0; i < 2; i++) begin
			c100 = (st_s2[i].yq4 == Q4_W'(st_s2[i].yq100) * Q4_W'(25));
			leap = (st_s2[i].ylo == 2'd0) && (!c100 || (st_s2[i].yq100[1:0] == 2'd0));
			nx3[i] = st_s2[i].base - COUNT_W'(st_s2[i].q100)
				+ COUNT_W'(st_s2[i].q100[Q100_W-1:2])
				+ COUNT_W'(leap && st_s2[i].late);
		end
	end

	always_comb begin
		logic [COUNT_W-1:0] diff;
		if (cnt_s3[1] > cnt_s3[0]) begin
			diff = cnt_s3[1] - cnt_s3[0];
		end else begin
			diff = cnt_s3[0] - cnt_s3[1];
		end
		nx4 = diff[COUNT_W-1] ? DIST_MAX : diff[DIST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) st_s1   <= nx1;
		if (en2) st_s2   <= nx2;
		if (en3) cnt_s3  <= nx3;
		if (en4) dist_s4 <= nx4;
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {2'b00, dist_s4};

	`ASSERT_PROP(a_s3_hold, clk, arst_n,
		v_s3 && v_s4 && !m_tready |=> v_s3 && $stable(cnt_s3[0]) && $stable(cnt_s3[1]))
	`ASSERT_PROP(a_full_stall, clk, arst_n, !s_tready |-> v_s1 && v_s2 && v_s3 && v_s4)
	`ASSERT_PROP(a_enter_s1, clk, arst_n, s_tvalid && s_tready |=> v_s1)

endmodule

// ===== sim/tb_gregorian_days_between_dates.sv =====
// ----------------------------------------------------------------------------
// tb_gregorian_days_between_dates
// Streams date pairs into the day distance block, predicts each distance from
// its own day count, and checks the results in order under varied idling.
// ----------------------------------------------------------------------------
module tb_gregorian_days_between_dates
	import gdbd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned PHASE_ITEMS    = 220;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	typedef struct packed {
		logic [1:0] pad;
		date_t      second;
		date_t      first;
	} date_pair_t;

	class distance_scoreboard;
		logic [DIST_W-1:0] expected_distance[$];
		int unsigned       mismatches;
		int unsigned       month_start[14];

		function new();
			month_start = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
			mismatches = 0;
		endfunction

		function int unsigned day_count(date_t dt);
			int unsigned y;
			int unsigned m;
			int unsigned n;
			int unsigned total;
			bit          leap;
			y = 32'(dt.year);
			m = 32'(dt.month);
			if (y > MAX_YEAR_DEF)
				y = MAX_YEAR_DEF;
			if (m > 13)
				m = 13;
			total = 32'(dt.day);
			if (y >= 1) begin
				n = y - 1;
				total += 365 * n + n / 4 - n / 100 + n / 400;
			end
			total += month_start[m];
			leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
			if (m >= MONTH_MARCH && leap)
				total += 1;
			return total;
		endfunction

		function void note_dates(logic [47:0] data);
			date_pair_t  p;
			int unsigned a;
			int unsigned b;
			int unsigned diff;
			p = data;
			a = day_count(p.first);
			b = day_count(p.second);
			diff = (b > a) ? b - a : a - b;
			if (diff > DIST_MAX)
				diff = DIST_MAX;
			expected_distance.push_back(diff[DIST_W-1:0]);
		endfunction

		task report_mismatch(string what);
			$display("%0t mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		task check_distance(logic [23:0] data);
			logic [DIST_W-1:0] want;
			if (expected_distance.size() == 0) begin
				report_mismatch($sformatf("distance %0d with none pending", data[DIST_W-1:0]));
			end else begin
				want = expected_distance.pop_front();
				if (data[DIST_W-1:0] !== want)
					report_mismatch($sformatf("day_distance %0d, want %0d",
						data[DIST_W-1:0], want));
			end
		endtask

		function int unsigned pending();
			return expected_distance.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// first_day, first_month, first_year, second_day, second_month,
	// second_year, 2'b0 pad
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// day_distance, 2'b0 pad
	logic [23:0] m_tdata;

	distance_scoreboard board;
	int unsigned        send_idle_pct = 0;
	int unsigned        recv_stall_pct = 0;
	logic               hold_req = 1'b0;
	int unsigned        hold_cnt = 0;
	int unsigned        quiet_cycles = 0;

	gregorian_days_between_dates uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req <= 1'b0;
			hold_cnt = LONG_HOLD;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			board.note_dates(s_tdata);
		if (m_tvalid && m_tready)
			board.check_distance(m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_gregorian_days_between_dates: errors");
				$finish;
			end
		end
	end

	function automatic date_t make_date(int unsigned d, int unsigned m, int unsigned y);
		date_t dt;
		dt.day = DAY_W'(d);
		dt.month = MONTH_W'(m);
		dt.year = YEAR_W'(y);
		return dt;
	endfunction

	function automatic date_t rand_date();
		date_t dt;
		case ($urandom_range(9))
			0: begin
				dt.day = DAY_W'($urandom);
				dt.month = MONTH_W'($urandom);
				dt.year = YEAR_W'($urandom);
			end
			1: begin
				dt = make_date($urandom_range(27, 31), $urandom_range(2, 3),
					$urandom_range(0, 99) * 100 + $urandom_range(0, 1) * 4);
			end
			default: begin
				dt = make_date($urandom_range(1, 31), $urandom_range(1, 12),
					$urandom_range(1, MAX_YEAR_DEF));
			end
		endcase
		return dt;
	endfunction

	function automatic date_pair_t rand_pair();
		date_pair_t p;
		p.pad = '0;
		p.first = rand_date();
		if ($urandom_range(3) == 0) begin
			p.second = p.first;
			p.second.day = DAY_W'($urandom_range(0, 31));
			if ($urandom_range(1))
				p.second.month = MONTH_W'($urandom_range(0, 15));
		end else begin
			p.second = rand_date();
		end
		return p;
	endfunction

	task automatic send_pair(date_pair_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_dates(date_t a, date_t b);
		date_pair_t p;
		p.pad = '0;
		p.first = a;
		p.second = b;
		send_pair(p);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(int unsigned idle, int unsigned stall, bit with_hold);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (with_hold && i == 40)
				hold_req <= 1'b1;
			send_pair(rand_pair());
		end
	endtask

	initial begin
		board = new();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_dates(make_date(1, 1, 1), make_date(1, 1, 1));
		send_dates(make_date(1, 1, 1), make_date(31, 12, 9999));
		send_dates(make_date(31, 12, 9999), make_date(1, 1, 1));
		send_dates(make_date(28, 2, 2000), make_date(1, 3, 2000));
		send_dates(make_date(28, 2, 1900), make_date(1, 3, 1900));
		send_dates(make_date(28, 2, 2004), make_date(1, 3, 2004));
		send_dates(make_date(31, 2, 2023), make_date(1, 3, 2023));
		send_dates(make_date(0, 1, 1), make_date(1, 1, 1));
		send_dates(make_date(5, 0, 2020), make_date(5, 1, 2020));
		send_dates(make_date(1, 13, 2020), make_date(1, 1, 2021));
		send_dates(make_date(1, 14, 2020), make_date(1, 15, 2019));
		send_dates(make_date(1, 3, 0), make_date(1, 1, 1));
		send_dates(make_date(1, 2, 0), make_date(1, 1, 1));
		send_dates(make_date(1, 1, 16383), make_date(1, 1, 9999));
		send_dates(make_date(1, 1, 10000), make_date(31, 12, 9998));
		send_dates(make_date(31, 15, 16383), make_date(0, 0, 0));
		send_dates(make_date(31, 15, 16383), make_date(31, 15, 16383));
		send_dates(make_date(0, 0, 0), make_date(0, 0, 0));
		send_dates(make_date(29, 2, 2100), make_date(1, 3, 2100));
		send_dates(make_date(16, 8, 8192), make_date(15, 7, 4096));
		drain();

		run_phase(0, 0, 1'b1);
		drain();
		run_phase(72, 0, 1'b0);
		run_phase(0, 72, 1'b0);
		run_phase(20, 20, 1'b0);
		drain();

		repeat (12) @(negedge clk);
		if (board.mismatches == 0)
			$display("tb_gregorian_days_between_dates: clean");
		else
			$display("tb_gregorian_days_between_dates: errors");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gdbd_pkg.sv
rtl/gregorian_days_between_dates.sv
sim/tb_gregorian_days_between_dates.sv
